FILE: src/vertex_perspective_projection_top_macros.svh
// assertion macros for the projection block
`ifndef VERTEX_PERSPECTIVE_PROJECTION_TOP_MACROS_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_TOP_MACROS_SVH

// implication checked at every clock edge out of reset
`define VPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpp assertion failed");

// next-cycle implication
`define VPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpp assertion failed");

`endif

FILE: src/vpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg
// types and constants shared by the perspective projection block
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int FOCAL_SCALE_DEF = 256;
    localparam int VTX_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int COEF_W   = 16;
    localparam int ROW_W    = 48;
    localparam int PROD_W   = COEF_W + DIFF_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int MAT_FRAC = 14;
    localparam int ROT_W    = ACC_W - MAT_FRAC;
    localparam int MAG_W    = ROT_W - 1;
    localparam int QB       = 17;
    localparam int HALF_W   = 14;
    localparam int SCR_W    = 16;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAM_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAM_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAM_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_HALF_W = 3'd6;
    localparam logic [IDX_W-1:0] REG_HALF_H = 3'd7;

    typedef struct packed {
        logic signed [VTX_W-1:0] vertex_x;
        logic signed [VTX_W-1:0] vertex_y;
        logic signed [VTX_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic signed [VTX_W-1:0] depth;
        logic                    zero_depth;
        logic                    clipped;
    } result_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]   orient;
        logic signed [VTX_W-1:0] cam_x;
        logic signed [VTX_W-1:0] cam_y;
        logic signed [VTX_W-1:0] cam_z;
        logic [HALF_W-1:0]       half_w;
        logic [HALF_W-1:0]       half_h;
    } cfg_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
    } rot_t;

endpackage

FILE: src/vpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_front
// camera offset and 3x3 rotation, three pipeline stages
// ----------------------------------------------------------------------------
module vpp_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vpp_pkg::vertex_t vertex,
    input  vpp_pkg::cfg_t    cfg,
    output logic             rot_valid,
    output vpp_pkg::rot_t    rot
);

    localparam int DW = vpp_pkg::DIFF_W;
    localparam int CW = vpp_pkg::COEF_W;
    localparam int PW = vpp_pkg::PROD_W;
    localparam int AW = vpp_pkg::ACC_W;

    logic [2:0]                 valid_reg;
    logic [2:0]                 valid_next;
    logic [2:0][DW-1:0]         d_reg;
    logic [2:0][DW-1:0]         d_next;
    logic [2:0][2:0][PW-1:0]    p_reg;
    logic [2:0][2:0][PW-1:0]    p_next;
    vpp_pkg::rot_t              rot_reg;
    vpp_pkg::rot_t              rot_next;
    logic [2:0][AW-1:0]         acc;
    logic [CW-1:0]              coef;

    assign valid_next = {valid_reg[1:0], push};

    always_comb
    begin
        d_next[0] = {vertex.vertex_x[31], vertex.vertex_x} - {cfg.cam_x[31], cfg.cam_x};
        d_next[1] = {vertex.vertex_y[31], vertex.vertex_y} - {cfg.cam_y[31], cfg.cam_y};
        d_next[2] = {vertex.vertex_z[31], vertex.vertex_z} - {cfg.cam_z[31], cfg.cam_z};
    end

    always_comb
    begin
        coef = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef = cfg.orient[r][CW*c +: CW];
                p_next[r][c] = PW'($signed({{(PW-CW){coef[CW-1]}}, coef})
                                 * $signed({{(PW-DW){d_reg[c][DW-1]}}, d_reg[c]}));
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = {{2{p_reg[r][0][PW-1]}}, p_reg[r][0]}
                   + {{2{p_reg[r][1][PW-1]}}, p_reg[r][1]}
                   + {{2{p_reg[r][2][PW-1]}}, p_reg[r][2]};
        end
        // arithmetic shift by the matrix fraction: floor
        rot_next.rx = acc[0][AW-1:vpp_pkg::MAT_FRAC];
        rot_next.ry = acc[1][AW-1:vpp_pkg::MAT_FRAC];
        rot_next.rz = acc[2][AW-1:vpp_pkg::MAT_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        p_reg   <= p_next;
        rot_reg <= rot_next;
    end

    assign rot_valid = valid_reg[2];
    assign rot       = rot_reg;

endmodule

FILE: src/vpp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_queue
// two-entry queue between the rotation front and the divide back
// ----------------------------------------------------------------------------
module vpp_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  vpp_pkg::rot_t wr_data,
    output logic          rd_valid,
    output vpp_pkg::rot_t rd_data
);

    vpp_pkg::rot_t mem_reg [0:1];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          pop;

    // the back end never stalls, so the head word leaves every cycle
    assign pop         = (count_reg != 2'd0);
    assign wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, wr_en} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_valid = pop;
    assign rd_data  = mem_reg[rd_ptr_reg];

endmodule

FILE: src/vpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_back
// pipelined rounded divide, screen offset, saturation and depth
// ----------------------------------------------------------------------------
module vpp_back
#(
    parameter int FOCAL_SCALE = vpp_pkg::FOCAL_SCALE_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  vpp_pkg::rot_t   rot,
    input  vpp_pkg::cfg_t   cfg,
    output logic            done,
    output vpp_pkg::result_t result
);

    localparam int QB   = vpp_pkg::QB;
    localparam int MW   = vpp_pkg::MAG_W;
    localparam int RW   = vpp_pkg::ROT_W;
    localparam int FSW  = $clog2(FOCAL_SCALE + 1);
    localparam int AW   = MW + FSW;
    localparam int NW   = AW + 2;
    localparam int DVW  = MW + 1;
    localparam int CPW  = (NW > DVW + QB) ? NW : DVW + QB;
    localparam int SW   = QB + 3;
    localparam int VW   = vpp_pkg::VTX_W;
    localparam logic signed [SW-1:0] SMAX = SW'(32767);
    localparam logic signed [SW-1:0] SMIN = -SW'(32768);

    typedef struct packed {
        logic          valid;
        logic          zero;
        logic          negx;
        logic          negy;
        logic          ovx;
        logic          ovy;
        logic [VW-1:0] depth;
    } tag_t;

    // stage b0
    tag_t            t0_reg;
    tag_t            t0_next;
    logic [AW-1:0]   ax_reg;
    logic [AW-1:0]   ax_next;
    logic [AW-1:0]   ay_reg;
    logic [AW-1:0]   ay_next;
    logic [MW-1:0]   b_reg;
    logic [MW-1:0]   b_next;
    logic [RW-1:0]   absx;
    logic [RW-1:0]   absy;
    logic [RW-1:0]   absz;
    logic [RW:0]     dsum;

    // divide stages, index 0 is the setup stage
    tag_t            t_reg   [0:QB];
    logic [NW-1:0]   rx_reg  [0:QB];
    logic [NW-1:0]   ry_reg  [0:QB];
    logic [DVW-1:0]  dv_reg  [0:QB];
    logic [QB-1:0]   qx_reg  [0:QB];
    logic [QB-1:0]   qy_reg  [0:QB];
    tag_t            t1_next;
    logic [NW-1:0]   nx_next;
    logic [NW-1:0]   ny_next;
    logic [DVW-1:0]  dv_next;

    logic            done_reg;
    logic            done_next;
    vpp_pkg::result_t res_reg;
    vpp_pkg::result_t res_next;

    function automatic logic [16:0] to_screen(input logic [QB-1:0] q, input logic neg,
                                              input logic ov, input logic [13:0] half);
        logic signed [SW-1:0] qe;
        logic signed [SW-1:0] s;
        logic                 clip;
        logic [15:0]          v;
        qe = $signed({3'b000, q});
        s  = (neg ? -qe : qe) + $signed({{(SW-14){1'b0}}, half});
        clip = 1'b1;
        if (ov)
        begin
            v = neg ? 16'h8000 : 16'h7fff;
        end
        else if (s > SMAX)
        begin
            v = 16'h7fff;
        end
        else if (s < SMIN)
        begin
            v = 16'h8000;
        end
        else
        begin
            v    = s[15:0];
            clip = 1'b0;
        end
        return {clip, v};
    endfunction

    always_comb
    begin
        absx = rot.rx[RW-1] ? -rot.rx : rot.rx;
        absy = rot.ry[RW-1] ? -rot.ry : rot.ry;
        absz = rot.rz[RW-1] ? -rot.rz : rot.rz;
        ax_next = AW'(absx[MW-1:0]) * AW'(FOCAL_SCALE);
        ay_next = AW'(absy[MW-1:0]) * AW'(FOCAL_SCALE);
        b_next  = absz[MW-1:0];
        dsum    = {rot.rz[RW-1], rot.rz} + {{(RW+1-VW){cfg.cam_z[VW-1]}}, cfg.cam_z};
        t0_next.valid = in_valid;
        t0_next.zero  = (rot.rz == '0);
        t0_next.negx  = rot.rx[RW-1] != rot.rz[RW-1];
        t0_next.negy  = rot.ry[RW-1] != rot.rz[RW-1];
        t0_next.ovx   = 1'b0;
        t0_next.ovy   = 1'b0;
        // depth saturation
        if (dsum[RW] && !(&dsum[RW-1:VW-1]))
        begin
            t0_next.depth = {1'b1, {(VW-1){1'b0}}};
        end
        else if (!dsum[RW] && (|dsum[RW-1:VW-1]))
        begin
            t0_next.depth = {1'b0, {(VW-1){1'b1}}};
        end
        else
        begin
            t0_next.depth = dsum[VW-1:0];
        end
    end

    // rounded quotient: (2a + b) / 2b
    always_comb
    begin
        nx_next = (NW'(ax_reg) << 1) + NW'(b_reg);
        ny_next = (NW'(ay_reg) << 1) + NW'(b_reg);
        dv_next = {b_reg, 1'b0};
        t1_next = t0_reg;
        t1_next.ovx = CPW'(nx_next) >= (CPW'(dv_next) << QB);
        t1_next.ovy = CPW'(ny_next) >= (CPW'(dv_next) << QB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg   <= '0;
            t_reg[0] <= '0;
        end
        else
        begin
            t0_reg   <= t0_next;
            t_reg[0] <= t1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        b_reg        <= b_next;
        rx_reg[0]    <= nx_next;
        ry_reg[0]    <= ny_next;
        dv_reg[0]    <= dv_next;
        qx_reg[0]    <= '0;
        qy_reg[0]    <= '0;
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int SH = QB - 1 - k;
        logic [CPW-1:0] dsh;
        logic           hitx;
        logic           hity;

        assign dsh  = CPW'(dv_reg[k]) << SH;
        assign hitx = CPW'(rx_reg[k]) >= dsh;
        assign hity = CPW'(ry_reg[k]) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                t_reg[k+1] <= '0;
            end
            else
            begin
                t_reg[k+1] <= t_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1]      <= dv_reg[k];
            rx_reg[k+1]      <= hitx ? NW'(CPW'(rx_reg[k]) - dsh) : rx_reg[k];
            ry_reg[k+1]      <= hity ? NW'(CPW'(ry_reg[k]) - dsh) : ry_reg[k];
            qx_reg[k+1]      <= qx_reg[k] | (QB'(hitx) << SH);
            qy_reg[k+1]      <= qy_reg[k] | (QB'(hity) << SH);
        end
    end

    always_comb
    begin
        logic [16:0] sx;
        logic [16:0] sy;
        sx = to_screen(qx_reg[QB], t_reg[QB].negx, t_reg[QB].ovx, cfg.half_w);
        sy = to_screen(qy_reg[QB], t_reg[QB].negy, t_reg[QB].ovy, cfg.half_h);
        done_next           = t_reg[QB].valid;
        res_next.depth      = t_reg[QB].depth;
        res_next.zero_depth = t_reg[QB].zero;
        if (t_reg[QB].zero)
        begin
            res_next.screen_x = '0;
            res_next.screen_y = '0;
            res_next.clipped  = 1'b0;
        end
        else
        begin
            res_next.screen_x = sx[15:0];
            res_next.screen_y = sy[15:0];
            res_next.clipped  = sx[16] | sy[16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: src/vertex_perspective_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_perspective_projection_top
// pinhole projection of one vertex per cycle into screen space
// path to the done strobe: front, queue, stage b0, divide setup, 17-stage divide, output register
// throughput: one vertex per cycle, busy stays low
// reset: asynchronous, registers return to identity matrix, camera at z 262144, 320x240
// ----------------------------------------------------------------------------
`include "vertex_perspective_projection_top_macros.svh"

module vertex_perspective_projection_top
#(
    parameter int FOCAL_SCALE = vpp_pkg::FOCAL_SCALE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  vpp_pkg::vertex_t                 vertex,
    input  logic                             cfg_we,
    input  logic [vpp_pkg::IDX_W-1:0]        cfg_index,
    input  logic [vpp_pkg::ROW_W-1:0]        cfg_data,
    output logic                             done,
    output vpp_pkg::result_t                 result
);

    vpp_pkg::cfg_t cfg_reg;
    vpp_pkg::cfg_t cfg_next;
    logic          push;
    logic          rot_valid;
    vpp_pkg::rot_t rot;
    logic          q_valid;
    vpp_pkg::rot_t q_data;

    assign busy = 1'b0;
    assign push = start & ~busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                vpp_pkg::REG_ROW_X:  cfg_next.orient[0] = cfg_data;
                vpp_pkg::REG_ROW_Y:  cfg_next.orient[1] = cfg_data;
                vpp_pkg::REG_ROW_Z:  cfg_next.orient[2] = cfg_data;
                vpp_pkg::REG_CAM_X:  cfg_next.cam_x = cfg_data[31:0];
                vpp_pkg::REG_CAM_Y:  cfg_next.cam_y = cfg_data[31:0];
                vpp_pkg::REG_CAM_Z:  cfg_next.cam_z = cfg_data[31:0];
                vpp_pkg::REG_HALF_W: cfg_next.half_w = cfg_data[13:0];
                vpp_pkg::REG_HALF_H: cfg_next.half_h = cfg_data[13:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orient[0] <= 48'h0000_0000_4000;
            cfg_reg.orient[1] <= 48'h0000_4000_0000;
            cfg_reg.orient[2] <= 48'h4000_0000_0000;
            cfg_reg.cam_x     <= 32'sd0;
            cfg_reg.cam_y     <= 32'sd0;
            cfg_reg.cam_z     <= 32'sd262144;
            cfg_reg.half_w    <= 14'd160;
            cfg_reg.half_h    <= 14'd120;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vpp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .vertex    (vertex),
        .cfg       (cfg_reg),
        .rot_valid (rot_valid),
        .rot       (rot)
    );

    vpp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rot_valid),
        .wr_data  (rot),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    vpp_back #(.FOCAL_SCALE(FOCAL_SCALE)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .rot      (q_data),
        .cfg      (cfg_reg),
        .done     (done),
        .result   (result)
    );

    // zero depth forces a zero, unclipped screen coordinate
    `VPP_ASSERT_IMPLY(a_zero_depth, clk, rst_n, done && result.zero_depth, result.screen_x == 16'sd0 && result.screen_y == 16'sd0 && !result.clipped)
    // a clipped word carries a coordinate at a rail
    `VPP_ASSERT_IMPLY(a_clip_rail, clk, rst_n, done && result.clipped, result.screen_x == 16'sh7fff || result.screen_x == 16'sh8000 || result.screen_y == 16'sh7fff || result.screen_y == 16'sh8000)
    // no word leaves an empty queue unless one arrives from the front
    `VPP_ASSERT_NEXT(a_idle_front, clk, rst_n, !rot_valid && !q_valid, !q_valid)

endmodule
